/* hdl/usw_pkg.sv */
package usw_pkg;

  localparam int MAX_DEPTH_DEF = 16;
  localparam int ROW_WIDTH_DEF = 64;

  localparam int TICK_W = 32;
  localparam int ROW_W  = 64;
  localparam int REQ_W  = 2;
  localparam int CFG_W  = 5;

  localparam int DEPTH_RST = 16;

  localparam logic [REQ_W-1:0] REQ_RECORD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CONFIRM = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TICK_W-1:0] tick;
    logic [ROW_W-1:0]  row_data;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              has_entry;
    logic [TICK_W-1:0] entry_tick;
    logic [ROW_W-1:0]  entry_row;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RECORD,
    S_TRIM,
    S_PURGE,
    S_READ,
    S_REPLY
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_WRAP,
    OP_LOAD,
    OP_ROW
  } cell_op_t;

  // Broadcast from the controller to every cell: the tick under test and the watermark.
  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic              wm_set;
    logic [TICK_W-1:0] wm;
  } probe_t;

endpackage

/* hdl/usw_cell.sv */
module usw_cell #(
  parameter int ROW_WIDTH = usw_pkg::ROW_WIDTH_DEF
) (
  input  logic                      clk,
  input  usw_pkg::cell_op_t         op,
  input  usw_pkg::probe_t           probe,
  input  logic [ROW_WIDTH-1:0]      new_row,
  input  logic [usw_pkg::TICK_W-1:0] nb_tick,
  input  logic [ROW_WIDTH-1:0]      nb_row,
  input  logic [usw_pkg::TICK_W-1:0] wrap_tick,
  input  logic [ROW_WIDTH-1:0]      wrap_row,
  output logic [usw_pkg::TICK_W-1:0] tick,
  output logic [ROW_WIDTH-1:0]      row,
  output logic                      hit,
  output logic                      removable
);
  import usw_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      OP_SHIFT: begin
        tick <= nb_tick;
        row  <= nb_row;
      end
      OP_WRAP: begin
        tick <= wrap_tick;
        row  <= wrap_row;
      end
      OP_LOAD: begin
        tick <= probe.tick;
        row  <= new_row;
      end
      OP_ROW: begin
        row <= new_row;
      end
      default: begin
      end
    endcase
  end

  assign hit       = (tick == probe.tick);
  assign removable = probe.wm_set && (tick <= probe.wm);

endmodule

/* hdl/unacked_sample_window.sv */
// Channel | Direction | Handshake           | Beat
// in      | input     | in_valid / in_stall   | in_data (req_type, tick, row_data)
// out     | output    | out_valid / out_stall | out_data (accepted .. last)
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (window_depth)
//
// Record: rejected or overwritten goes straight to the reply; an append first drops the oldest
// if full, then evicts down to the depth. Confirm: removes entries; no result beat.
// Read: one beat per held entry, one per cycle while out_stall is low (one beat if empty).
// One request at a time; the row of cells moves at most one place per cycle.
// Reset (rst, synchronous) empties the window and clears the watermark; depth returns to 16 (capped at MAX_DEPTH).
// out_stall holds the result register and the sequencer; in_stall is high while busy.
module unacked_sample_window #(
  parameter int MAX_DEPTH = usw_pkg::MAX_DEPTH_DEF,
  parameter int ROW_WIDTH = usw_pkg::ROW_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  usw_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output usw_pkg::out_item_t       out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [usw_pkg::CFG_W-1:0] cfg_data
);
  import usw_pkg::*;

  localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
  localparam int DEPTH_R = (DEPTH_RST > MAX_DEPTH) ? MAX_DEPTH : DEPTH_RST;

  state_t state, state_next;

  logic [REQ_W-1:0]     req;
  logic [TICK_W-1:0]    tk;
  logic [ROW_WIDTH-1:0] row;
  logic                 wm_set;
  logic [TICK_W-1:0]    wm;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     depth;
  logic [CNT_W-1:0]     depth_next;
  logic [CNT_W-1:0]     rd_idx;
  logic                 rep_acc, rep_acc_next;
  out_item_t            out_item_next;
  logic                 out_load;

  logic                 in_beat;
  logic                 slot_free;
  logic                 reject;
  logic                 rd_last;
  logic                 any_hit;
  logic                 any_rm;
  logic                 full;
  probe_t               probe;

  logic [TICK_W-1:0]    cell_tick [MAX_DEPTH];
  logic [ROW_WIDTH-1:0] cell_row  [MAX_DEPTH];
  logic [TICK_W-1:0]    nb_tick   [MAX_DEPTH];
  logic [ROW_WIDTH-1:0] nb_row    [MAX_DEPTH];
  cell_op_t             cell_op   [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] cell_hit;
  logic [MAX_DEPTH-1:0] cell_rm;
  logic [MAX_DEPTH-1:0] held;
  logic [MAX_DEPTH-1:0] hit_vec;
  logic [MAX_DEPTH-1:0] rm_vec;
  logic [MAX_DEPTH-1:0] rm_pre;

  assign probe = '{tick: tk, wm_set: wm_set, wm: wm};

  // Row of cells: each one takes its upper neighbour on a shift.
  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
    if (g == MAX_DEPTH - 1) begin : g_top
      assign nb_tick[g] = '0;
      assign nb_row[g]  = '0;
    end else begin : g_mid
      assign nb_tick[g] = cell_tick[g+1];
      assign nb_row[g]  = cell_row[g+1];
    end

    usw_cell #(
      .ROW_WIDTH(ROW_WIDTH)
    ) u_cell (
      .clk      (clk),
      .op       (cell_op[g]),
      .probe    (probe),
      .new_row  (row),
      .nb_tick  (nb_tick[g]),
      .nb_row   (nb_row[g]),
      .wrap_tick(cell_tick[0]),
      .wrap_row (cell_row[0]),
      .tick     (cell_tick[g]),
      .row      (cell_row[g]),
      .hit      (cell_hit[g]),
      .removable(cell_rm[g])
    );

    assign held[g]    = (CNT_W'(g) < count);
    // A cell moves on a purge when any removable entry sits at or below it.
    assign rm_pre[g]  = |(rm_vec & ({MAX_DEPTH{1'b1}} >> (MAX_DEPTH - 1 - g)));
  end

  assign hit_vec   = cell_hit & held;
  assign rm_vec    = cell_rm & held;
  assign any_hit   = |hit_vec;
  assign any_rm    = |rm_vec;
  assign full      = (count == CNT_W'(MAX_DEPTH));
  assign reject    = wm_set && (tk <= wm);
  assign rd_last   = ((CNT_W+1)'(rd_idx) + 1'b1) == (CNT_W+1)'(count);
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data == '0) begin
      depth_next = CNT_W'(1);
    end else if (int'(cfg_data) > MAX_DEPTH) begin
      depth_next = CNT_W'(MAX_DEPTH);
    end else begin
      depth_next = CNT_W'(cfg_data);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          case (in_data.req_type)
            REQ_RECORD:  state_next = S_RECORD;
            REQ_CONFIRM: state_next = S_PURGE;
            REQ_READ:    state_next = (count == '0) ? S_REPLY : S_READ;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_RECORD: begin
        if (reject || any_hit) begin
          state_next = S_REPLY;
        end else if (!full) begin
          state_next = S_TRIM;
        end
      end
      S_TRIM: begin
        if (count <= depth) begin
          state_next = S_REPLY;
        end
      end
      S_PURGE: begin
        if (!any_rm) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (slot_free && rd_last) begin
          state_next = S_IDLE;
        end
      end
      S_REPLY: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      cell_op[i] = OP_HOLD;
    end
    count_next    = count;
    rep_acc_next  = rep_acc;
    out_load      = 1'b0;
    out_item_next = '0;
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          rep_acc_next = 1'b0;
        end
      end
      S_RECORD: begin
        if (reject) begin
          rep_acc_next = 1'b0;
        end else if (any_hit) begin
          rep_acc_next = 1'b1;
          for (int i = 0; i < MAX_DEPTH; i++) begin
            if (hit_vec[i]) begin
              cell_op[i] = OP_ROW;
            end
          end
        end else if (full) begin
          // drop the oldest to make room, append next cycle
          for (int i = 0; i < MAX_DEPTH; i++) begin
            cell_op[i] = OP_SHIFT;
          end
          count_next = count - 1'b1;
        end else begin
          rep_acc_next = 1'b1;
          for (int i = 0; i < MAX_DEPTH; i++) begin
            if (CNT_W'(i) == count) begin
              cell_op[i] = OP_LOAD;
            end
          end
          count_next = count + 1'b1;
        end
      end
      S_TRIM: begin
        if (count > depth) begin
          for (int i = 0; i < MAX_DEPTH; i++) begin
            cell_op[i] = OP_SHIFT;
          end
          count_next = count - 1'b1;
        end
      end
      S_PURGE: begin
        if (any_rm) begin
          for (int i = 0; i < MAX_DEPTH; i++) begin
            if (rm_pre[i]) begin
              cell_op[i] = OP_SHIFT;
            end
          end
          count_next = count - 1'b1;
        end
      end
      S_READ: begin
        if (slot_free) begin
          out_load                 = 1'b1;
          out_item_next.has_entry  = 1'b1;
          out_item_next.entry_tick = cell_tick[0];
          out_item_next.entry_row  = ROW_W'(cell_row[0]);
          out_item_next.last       = rd_last;
          // rotate the held entries so the next one reaches the head
          for (int i = 0; i < MAX_DEPTH; i++) begin
            if ((CNT_W+1)'(i) + 1'b1 < (CNT_W+1)'(count)) begin
              cell_op[i] = OP_SHIFT;
            end else if ((CNT_W+1)'(i) + 1'b1 == (CNT_W+1)'(count)) begin
              cell_op[i] = OP_WRAP;
            end
          end
        end
      end
      S_REPLY: begin
        if (slot_free) begin
          out_load               = 1'b1;
          out_item_next.accepted = rep_acc;
          out_item_next.last     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      wm_set    <= 1'b0;
      depth     <= CNT_W'(DEPTH_R);
      out_valid <= 1'b0;
      rd_idx    <= '0;
      rep_acc   <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rep_acc <= rep_acc_next;
      if (cfg_valid && cfg_ready) begin
        depth <= depth_next;
      end
      if (in_beat) begin
        rd_idx <= '0;
        if (in_data.req_type == REQ_CONFIRM && (!wm_set || in_data.tick > wm)) begin
          wm_set <= 1'b1;
        end
      end else if (state == S_READ && slot_free) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      req <= in_data.req_type;
      tk  <= in_data.tick;
      row <= ROW_WIDTH'(in_data.row_data);
      if (in_data.req_type == REQ_CONFIRM && (!wm_set || in_data.tick > wm)) begin
        wm <= in_data.tick;
      end
    end
    if (out_load) begin
      out_data <= out_item_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DEPTH))
    else $error("window holds more entries than cells");

  assert property (@(posedge clk) disable iff (rst)
    (CNT_W+1)'(count) <= (CNT_W+1)'($past(count)) + 1'b1)
    else $error("window grew by more than one entry in a cycle");

  assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> count != '0)
    else $error("streaming an empty window");

  assert property (@(posedge clk) disable iff (rst)
    in_beat && in_data.req_type == REQ_CONFIRM |=> wm_set)
    else $error("confirm left the watermark unset");

  assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> req != REQ_CONFIRM || state == S_PURGE)
    else $error("confirm request in a foreign sequencer state");

endmodule

/* test/tb_top.sv */
module tb_top;
  import usw_pkg::*;

  localparam int WIN_SLOTS = MAX_DEPTH_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 50;
  localparam int HEAD_ROWS = 15;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  unacked_sample_window u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predicted window contents, oldest first
  logic [TICK_W-1:0] win_tick [WIN_SLOTS];
  logic [ROW_W-1:0]  win_row [WIN_SLOTS];
  int                win_count = 0;
  longint            win_watermark = -1;
  logic [CFG_W-1:0]  win_depth = CFG_W'(DEPTH_RST);

  out_item_t         reply_q [$];
  stim_row_t         script [$];
  logic [TICK_W-1:0] tick_base = 32'd200;
  int                mismatches = 0;
  bit                calm = 1'b0;
  bit                hold_off_now = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  function automatic int live_depth();
    int d;
    d = win_depth;
    if (d == 0) d = 1;
    if (d > WIN_SLOTS) d = WIN_SLOTS;
    return d;
  endfunction

  task automatic drop_oldest();
    for (int i = 1; i < win_count; i++) begin
      win_tick[i-1] = win_tick[i];
      win_row[i-1]  = win_row[i];
    end
    if (win_count > 0) win_count--;
  endtask

  // Advance the predicted window by one request and queue the beats it owes
  task automatic apply_request(in_item_t rq);
    longint    tk;
    longint    held;
    int        hit;
    int        kept;
    out_item_t beat;
    tk = rq.tick;
    beat = '0;
    beat.last = 1'b1;
    case (rq.req_type)
      REQ_RECORD: begin
        if (tk > win_watermark) begin
          beat.accepted = 1'b1;
          hit = -1;
          for (int i = 0; i < win_count; i++)
            if (win_tick[i] == rq.tick) hit = i;
          if (hit >= 0) begin
            win_row[hit] = rq.row_data;
          end else begin
            if (win_count >= WIN_SLOTS) drop_oldest();
            win_tick[win_count] = rq.tick;
            win_row[win_count]  = rq.row_data;
            win_count++;
            while (win_count > live_depth()) drop_oldest();
          end
        end
        reply_q = {reply_q, beat};
      end
      REQ_CONFIRM: begin
        if (tk > win_watermark) win_watermark = tk;
        kept = 0;
        for (int i = 0; i < win_count; i++) begin
          held = win_tick[i];
          if (held > win_watermark) begin
            win_tick[kept] = win_tick[i];
            win_row[kept]  = win_row[i];
            kept++;
          end
        end
        win_count = kept;
      end
      REQ_READ: begin
        if (win_count == 0) reply_q = {reply_q, beat};
        for (int i = 0; i < win_count; i++) begin
          beat.has_entry  = 1'b1;
          beat.entry_tick = win_tick[i];
          beat.entry_row  = win_row[i];
          beat.last       = (i == win_count - 1);
          reply_q = {reply_q, beat};
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_row(logic [REQ_W-1:0] rt, logic [TICK_W-1:0] tk, logic [ROW_W-1:0] rw,
                         bit typed, logic acc);
    stim_row_t r;
    r.req.req_type   = rt;
    r.req.tick       = tk;
    r.req.row_data   = rw;
    r.typed          = typed;
    r.want           = '0;
    r.want.accepted  = acc;
    r.want.last      = 1'b1;
    script = {script, r};
  endtask

  // Mostly ticks just ahead of a creeping base, with some stray and stale ones
  function automatic in_item_t rand_request();
    in_item_t rq;
    int       pick;
    pick = $urandom_range(0, 99);
    rq.row_data = {$urandom, $urandom};
    rq.tick = $urandom;
    if (pick < 45) begin
      rq.req_type = REQ_RECORD;
      rq.tick = tick_base + $urandom_range(0, 15);
      tick_base += $urandom_range(0, 2);
    end else if (pick < 55) begin
      rq.req_type = REQ_RECORD;
    end else if (pick < 72) begin
      rq.req_type = REQ_CONFIRM;
      rq.tick = tick_base - $urandom_range(0, 12);
    end else if (pick < 76) begin
      rq.req_type = REQ_CONFIRM;
      rq.tick = $urandom_range(0, tick_base);
    end else if (pick < 97) begin
      rq.req_type = REQ_READ;
    end else begin
      rq.req_type = REQ_UNUSED;
    end
    if ($urandom_range(0, 49) == 0) tick_base += $urandom_range(1000, 1 << 20);
    return rq;
  endfunction

  task automatic send_req(in_item_t it, bit typed, out_item_t want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(it);
    if (typed) reply_q[reply_q.size() - 1] = want;
  endtask

  // Drain every owed beat, then leave room for a confirm still purging
  task automatic settle();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    win_depth = d;
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] depth_plan [7];
    depth_plan = '{5'd0, 5'd31, 5'd3, 5'd1, 5'd8, 5'd17, 5'd16};
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;

    add_row(REQ_READ,    32'd0,          64'd0,                  1'b1, 1'b0);
    add_row(REQ_RECORD,  32'd0,          64'd0,                  1'b1, 1'b1);
    add_row(REQ_RECORD,  32'hFFFF_FFFF,  {ROW_W{1'b1}},          1'b1, 1'b1);
    add_row(REQ_RECORD,  32'd0,          64'h5555_5555_5555_5555, 1'b1, 1'b1);
    add_row(REQ_READ,    32'd0,          64'd0,                  1'b0, 1'b0);
    add_row(REQ_CONFIRM, 32'd0,          64'd0,                  1'b0, 1'b0);
    add_row(REQ_RECORD,  32'd0,          64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0);
    add_row(REQ_RECORD,  32'd100,        64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1);
    add_row(REQ_RECORD,  32'd50,         64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b1);
    add_row(REQ_CONFIRM, 32'd60,         64'd0,                  1'b0, 1'b0);
    add_row(REQ_CONFIRM, 32'd10,         64'd0,                  1'b0, 1'b0);
    add_row(REQ_RECORD,  32'd60,         64'hFFFF_0000_FFFF_0000, 1'b1, 1'b0);
    add_row(REQ_RECORD,  32'd61,         64'h0000_FFFF_0000_FFFF, 1'b1, 1'b1);
    add_row(REQ_UNUSED,  32'hDEAD_BEEF,  64'hC0FF_EE00_C0FF_EE00, 1'b0, 1'b0);
    add_row(REQ_READ,    32'd0,          64'd0,                  1'b0, 1'b0);
    // Tail: confirm everything, nothing can ever be recorded again
    add_row(REQ_CONFIRM, 32'hFFFF_FFFF,  64'd0,                  1'b0, 1'b0);
    add_row(REQ_READ,    32'd0,          64'd0,                  1'b1, 1'b0);
    add_row(REQ_RECORD,  32'hFFFF_FFFF,  {ROW_W{1'b1}},          1'b1, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < HEAD_ROWS; n++)
      send_req(script[n].req, script[n].typed, script[n].want);

    // Starve the output early so the block backs up onto its input
    hold_off_now = 1'b1;
    for (int n = 0; n < PHASE_ITEMS; n++) send_req(rand_request(), 1'b0, '0);

    for (int p = 0; p < 7; p++) begin
      settle();
      write_depth(depth_plan[p]);
      if (p == 6) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_req(rand_request(), 1'b0, '0);
    end

    for (int n = HEAD_ROWS; n < script.size(); n++)
      send_req(script[n].req, script[n].typed, script[n].want);
    settle();

    if (mismatches == 0) begin
      $display("unacked_sample_window verification clean");
    end else begin
      $display("unacked_sample_window verification failed");
    end
    $finish;
  end

  initial begin : out_backpressure
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_now) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_now = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : beat_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        report($sformatf("unexpected beat tick %h row %h", out_data.entry_tick,
                         out_data.entry_row));
      end else begin
        want = reply_q.pop_front();
        if (out_data.accepted !== want.accepted)
          report($sformatf("accepted got %b want %b", out_data.accepted, want.accepted));
        if (out_data.has_entry !== want.has_entry)
          report($sformatf("has_entry got %b want %b", out_data.has_entry, want.has_entry));
        if (out_data.entry_tick !== want.entry_tick)
          report($sformatf("entry_tick got %h want %h", out_data.entry_tick, want.entry_tick));
        if (out_data.entry_row !== want.entry_row)
          report($sformatf("entry_row got %h want %h", out_data.entry_row, want.entry_row));
        if (out_data.last !== want.last)
          report($sformatf("last got %b want %b", out_data.last, want.last));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("unacked_sample_window verification failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/usw_pkg.sv
hdl/usw_cell.sv
hdl/unacked_sample_window.sv
test/tb_top.sv
